[rtl/art_pkg.sv]
`default_nettype none

package art_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int COUNT_BITS    = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_CONFLICT    = 3'd1,
    STAT_FULL        = 3'd2,
    STAT_NOT_FOUND   = 3'd3,
    STAT_COUNT_LIMIT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_INC    = 3'd1,
    OP_DEC    = 3'd2,
    OP_FREE   = 3'd3
  } op_t;

  // Request fields broadcast to every cell while a search runs
  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        excl;
  } req_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             hit_excl;
    logic             hit_cnt_max;
    logic             hit_cnt_le1;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } tok_t;

  // Entry update command, applied by the addressed cell
  typedef struct packed {
    logic             en;
    op_t              op;
    logic [IDX_W-1:0] idx;
  } upd_t;

endpackage

`default_nettype wire

[rtl/art_cell.sv]
`default_nettype none

module art_cell import art_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire req_t             req,
  input  wire tok_t             tok_i,
  output tok_t                  tok_o,
  input  wire upd_t             upd
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic [63:0]           addr_hi_r;
  logic [63:0]           addr_hi_nxt;
  logic [63:0]           addr_lo_r;
  logic [63:0]           addr_lo_nxt;
  logic                  excl_r;
  logic                  excl_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  tok_t                  tok_r;
  tok_t                  tok_nxt;
  logic                  match;

  assign match = valid_r && (addr_hi_r == req.addr_hi) && (addr_lo_r == req.addr_lo);

  // Keep the first hit and the first free slot seen along the chain
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.active) begin
      if (!tok_i.hit && match) begin
        tok_nxt.hit         = 1'b1;
        tok_nxt.hit_idx     = cell_idx;
        tok_nxt.hit_excl    = excl_r;
        tok_nxt.hit_cnt_max = &cnt_r;
        tok_nxt.hit_cnt_le1 = (cnt_r <= COUNT_BITS'(1));
      end
      if (!tok_i.free && !valid_r) begin
        tok_nxt.free     = 1'b1;
        tok_nxt.free_idx = cell_idx;
      end
    end
  end

  always_comb begin
    valid_nxt   = valid_r;
    addr_hi_nxt = addr_hi_r;
    addr_lo_nxt = addr_lo_r;
    excl_nxt    = excl_r;
    cnt_nxt     = cnt_r;
    if (upd.en && (upd.idx == cell_idx)) begin
      case (upd.op)
        OP_CREATE: begin
          valid_nxt   = 1'b1;
          addr_hi_nxt = req.addr_hi;
          addr_lo_nxt = req.addr_lo;
          excl_nxt    = req.excl;
          cnt_nxt     = req.excl ? '0 : COUNT_BITS'(1);
        end
        OP_INC:  cnt_nxt = cnt_r + COUNT_BITS'(1);
        OP_DEC:  cnt_nxt = cnt_r - COUNT_BITS'(1);
        OP_FREE: begin
          valid_nxt = 1'b0;
          cnt_nxt   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_hi_r <= addr_hi_nxt;
    addr_lo_r <= addr_lo_nxt;
    excl_r    <= excl_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

[rtl/address_reservation_table_unit.sv]
`default_nettype none

// Channel  Dir  tdata (low bit up)                         tuser
// in_      in   addr_hi[63:0] addr_lo[127:64] excl[128]    req_type (0 hold, 1 release)
//               pad to 136 bits
// out_     out  status[2:0] created[3] freed[4], pad to 8  -
//
// One transaction at a time: from input accept, the search token walks the cell chain
// one cell a cycle, then the outcome is decided and registered as the result.
// Synchronous active-low reset empties the table; no clearing pass.
// A new transaction is accepted while the previous result still waits in the output
// register; a stalled output holds the finished search until the result slot frees.

module address_reservation_table_unit import art_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,   // addr_hi, addr_lo, exclusive, zero pad
  input  wire logic         in_tuser,   // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata   // status, created, freed, zero pad
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  req_t    req_r;
  logic    rel_r;
  logic    start_r;
  tok_t    res_r;
  tok_t    tok [TABLE_ENTRIES+1];
  upd_t    upd;
  status_t stat;
  logic    created;
  logic    freed;
  logic    out_valid_r;
  status_t status_r;
  logic    created_r;
  logic    freed_r;
  logic    in_acc;
  logic    out_free;
  logic    commit;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign commit    = (state_r == S_DECIDE) && out_free;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = start_r;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    art_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .req      (req_r),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .upd      (upd)
    );
  end

  // Decide the outcome from the finished search
  always_comb begin
    stat    = STAT_OK;
    created = 1'b0;
    freed   = 1'b0;
    upd.en  = 1'b0;
    upd.op  = OP_CREATE;
    upd.idx = res_r.hit_idx;
    if (!rel_r) begin
      if (!res_r.hit) begin
        if (res_r.free) begin
          upd.en  = 1'b1;
          upd.op  = OP_CREATE;
          upd.idx = res_r.free_idx;
          created = 1'b1;
        end else begin
          stat = STAT_FULL;
        end
      end else if (!req_r.excl && !res_r.hit_excl) begin
        if (res_r.hit_cnt_max) begin
          stat = STAT_COUNT_LIMIT;
        end else begin
          upd.en = 1'b1;
          upd.op = OP_INC;
        end
      end else begin
        stat = STAT_CONFLICT;
      end
    end else begin
      if (!res_r.hit) begin
        stat = STAT_NOT_FOUND;
      end else if (res_r.hit_excl || res_r.hit_cnt_le1) begin
        upd.en = 1'b1;
        upd.op = OP_FREE;
        freed  = 1'b1;
      end else begin
        upd.en = 1'b1;
        upd.op = OP_DEC;
      end
    end
    upd.en = upd.en && commit;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_SEARCH;
      S_SEARCH: if (tok[TABLE_ENTRIES].active) state_nxt = S_DECIDE;
      S_DECIDE: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.addr_hi <= in_tdata[63:0];
      req_r.addr_lo <= in_tdata[127:64];
      req_r.excl    <= in_tdata[128];
      rel_r         <= in_tuser;
    end
    // hold the search outcome until the result slot frees
    if ((state_r == S_SEARCH) && tok[TABLE_ENTRIES].active) begin
      res_r <= tok[TABLE_ENTRIES];
    end
    if (commit) begin
      status_r  <= stat;
      created_r <= created;
      freed_r   <= freed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, freed_r, created_r, status_r};

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import art_pkg::*;

  localparam bit REQ_HOLD    = 1'b0;
  localparam bit REQ_RELEASE = 1'b1;
  localparam int POOL_SIZE   = 24;
  localparam int RANDOM_REQS = 700;
  localparam longint unsigned CYCLE_LIMIT = 12_000_000;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_t;

  typedef struct {
    status_t status;
    bit      created;
    bit      freed;
  } verdict_t;

  // Mirror of the reservation table plus the verdicts still owed by the block
  class reservation_tracker;
    bit                  slot_used [TABLE_ENTRIES];
    bit [63:0]           slot_hi   [TABLE_ENTRIES];
    bit [63:0]           slot_lo   [TABLE_ENTRIES];
    bit                  slot_excl [TABLE_ENTRIES];
    bit [COUNT_BITS-1:0] slot_cnt  [TABLE_ENTRIES];
    verdict_t            pending_verdicts[$];
    int                  errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    function void note_request(bit is_release, addr_t a, bit ex);
      int       hit;
      int       slot;
      verdict_t v;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!slot_used[i] && slot < 0) slot = i;
        if (slot_used[i] && slot_hi[i] == a.hi && slot_lo[i] == a.lo && hit < 0) hit = i;
      end
      v.status  = STAT_OK;
      v.created = 1'b0;
      v.freed   = 1'b0;
      if (!is_release) begin
        if (hit < 0) begin
          if (slot < 0) begin
            v.status = STAT_FULL;
          end else begin
            slot_used[slot] = 1'b1;
            slot_hi[slot]   = a.hi;
            slot_lo[slot]   = a.lo;
            slot_excl[slot] = ex;
            slot_cnt[slot]  = ex ? '0 : COUNT_BITS'(1);
            v.created       = 1'b1;
          end
        end else if (!ex && !slot_excl[hit]) begin
          if (&slot_cnt[hit]) v.status = STAT_COUNT_LIMIT;
          else slot_cnt[hit] = slot_cnt[hit] + 1'b1;
        end else begin
          v.status = STAT_CONFLICT;
        end
      end else begin
        if (hit < 0) begin
          v.status = STAT_NOT_FOUND;
        end else if (slot_excl[hit] || slot_cnt[hit] <= 1) begin
          slot_used[hit] = 1'b0;
          slot_cnt[hit]  = '0;
          v.freed        = 1'b1;
        end else begin
          slot_cnt[hit] = slot_cnt[hit] - 1'b1;
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic [7:0] data);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result transaction: data %h", data);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (data[2:0] !== v.status) begin
        $error("status: expected %0d, got %0d", v.status, data[2:0]);
        errors++;
      end
      if (data[3] !== v.created) begin
        $error("created: expected %0d, got %0d", v.created, data[3]);
        errors++;
      end
      if (data[4] !== v.freed) begin
        $error("freed: expected %0d, got %0d", v.freed, data[4]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;

  reservation_tracker tracker = new();
  addr_t              pool[POOL_SIZE];
  bit                 calm;
  longint unsigned    cycles;

  address_reservation_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic addr_t random_addr();
    addr_t a;
    a.hi = {$urandom, $urandom};
    a.lo = {$urandom, $urandom};
    return a;
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic issue(bit is_release, addr_t a, bit ex);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_release;
    in_tdata  <= {7'b0, ex, a.lo, a.hi};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(is_release, a, ex);
  endtask

  // Result side: check each transaction, stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** address_reservation_table_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int hold_bias;
    addr_t a;
    calm = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_HOLD;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    pool[0] = '{hi: '0, lo: '0};
    pool[1] = '{hi: '1, lo: '1};
    pool[2] = '{hi: '1, lo: '0};
    pool[3] = '{hi: '0, lo: '1};
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i % 2 == 1) begin
        // neighbor differing in one address bit
        pool[i] = pool[i-1];
        pool[i][$urandom_range(0, 127)] ^= 1'b1;
      end else begin
        pool[i] = random_addr();
      end
    end

    // Exclusive life cycle, including release of an unknown address
    issue(REQ_RELEASE, pool[0], 1'b0);
    issue(REQ_HOLD,    pool[0], 1'b1);
    issue(REQ_HOLD,    pool[0], 1'b1);
    issue(REQ_HOLD,    pool[0], 1'b0);
    issue(REQ_RELEASE, pool[0], 1'b1);
    // Shared life cycle; exclusive bit on release is ignored
    issue(REQ_HOLD,    pool[1], 1'b0);
    issue(REQ_HOLD,    pool[1], 1'b0);
    issue(REQ_HOLD,    pool[1], 1'b1);
    issue(REQ_RELEASE, pool[1], 1'b1);
    issue(REQ_RELEASE, pool[1], 1'b0);
    // Fill the table, then overflow it
    for (int i = 0; i < TABLE_ENTRIES; i++) issue(REQ_HOLD, pool[i], (i % 3) == 0);
    issue(REQ_HOLD, pool[TABLE_ENTRIES], 1'b0);

    hold_bias = 50;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        hold_bias = $urandom_range(30, 75);
      end
      if ($urandom_range(0, 9) == 0) a = random_addr();
      else a = pool[$urandom_range(0, POOL_SIZE - 1)];
      issue(($urandom_range(0, 99) >= hold_bias) ? REQ_RELEASE : REQ_HOLD, a,
            $urandom_range(0, 2) == 0);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("** address_reservation_table_unit: PASSED **");
    end else begin
      $display("** address_reservation_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
